### rtl/core/nqg_pkg.sv
`default_nettype none
package nqg_pkg;
   localparam int MAX_WIDTH_DEF    = 1024;
   localparam int MAX_CHANNELS_DEF = 4;

   localparam logic [1:0] CSR_WIDTH    = 2'd0;
   localparam logic [1:0] CSR_HEIGHT   = 2'd1;
   localparam logic [1:0] CSR_CHANNELS = 2'd2;

   localparam int Q_BITS   = 16;
   localparam int SUM_BITS = 13;

   typedef struct packed {
      logic [7:0] pixel_sample;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic signed [15:0] grad_x;
      logic signed [15:0] grad_y;
      logic [1:0]         channel_index;
      logic               frame_end;
   } rsp_type;

   // job handed from the window stage to the divider
   typedef struct packed {
      logic [SUM_BITS-1:0] total;
      logic [SUM_BITS-1:0] mag_x;
      logic [SUM_BITS-1:0] mag_y;
      logic                neg_x;
      logic                neg_y;
      logic [1:0]          channel_index;
      logic                frame_end;
   } job_type;
endpackage
`default_nettype wire

### rtl/core/nqg_divider.sv
`default_nettype none
module nqg_divider (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   job_valid,
   input  nqg_pkg::job_type      job,
   output logic                  busy,
   output logic                  done_valid,
   input  wire                   done_take,
   output nqg_pkg::rsp_type      done
);
   import nqg_pkg::*;

   localparam int CNT_BITS = 5;

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [SUM_BITS:0]    rx_ff, rx_in, ry_ff, ry_in;
   logic [Q_BITS-1:0]    qx_ff, qx_in, qy_ff, qy_in;
   job_type              job_ff, job_in;
   rsp_type              out_ff, out_in;
   logic [SUM_BITS+1:0]  tx, ty;

   assign busy       = run_ff | (done_ff & ~done_take);
   assign done_valid = done_ff;
   assign done       = out_ff;

   // restoring division of (mag << 15) by total, one quotient bit a cycle
   always_comb begin
      run_in  = run_ff;
      done_in = done_ff & ~done_take;
      cnt_in  = cnt_ff;
      rx_in   = rx_ff;
      ry_in   = ry_ff;
      qx_in   = qx_ff;
      qy_in   = qy_ff;
      job_in  = job_ff;
      out_in  = out_ff;
      tx = {rx_ff, 1'b0};
      ty = {ry_ff, 1'b0};
      if (cnt_ff == '0) begin
         tx[0] = 1'b0;
         ty[0] = 1'b0;
      end
      if (job_valid && !busy) begin
         run_in = 1'b1;
         job_in = job;
         cnt_in = CNT_BITS'(Q_BITS - 1);
         rx_in  = {1'b0, job.mag_x};
         ry_in  = {1'b0, job.mag_y};
         qx_in  = '0;
         qy_in  = '0;
      end else if (run_ff) begin
         if (tx >= {2'b0, job_ff.total}) begin
            rx_in = (SUM_BITS+1)'(tx - {2'b0, job_ff.total});
            qx_in = {qx_ff[Q_BITS-2:0], 1'b1};
         end else begin
            rx_in = tx[SUM_BITS:0];
            qx_in = {qx_ff[Q_BITS-2:0], 1'b0};
         end
         if (ty >= {2'b0, job_ff.total}) begin
            ry_in = (SUM_BITS+1)'(ty - {2'b0, job_ff.total});
            qy_in = {qy_ff[Q_BITS-2:0], 1'b1};
         end else begin
            ry_in = ty[SUM_BITS:0];
            qy_in = {qy_ff[Q_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
            out_in.grad_x = job_ff.neg_x ? -$signed(qx_in) : $signed(qx_in);
            out_in.grad_y = job_ff.neg_y ? -$signed(qy_in) : $signed(qy_in);
            out_in.channel_index = job_ff.channel_index;
            out_in.frame_end     = job_ff.frame_end;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rx_ff  <= rx_in;
      ry_ff  <= ry_in;
      qx_ff  <= qx_in;
      qy_ff  <= qy_in;
      job_ff <= job_in;
      out_ff <= out_in;
   end
endmodule
`default_nettype wire

### rtl/core/nqg_window.sv
`default_nettype none
module nqg_window #(
   parameter int MAX_WIDTH    = nqg_pkg::MAX_WIDTH_DEF,
   parameter int MAX_CHANNELS = nqg_pkg::MAX_CHANNELS_DEF
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                csr_write,
   input  wire [10:0]         image_width,
   input  wire [15:0]         image_height,
   input  wire [2:0]          channel_count,
   input  wire                in_valid,
   input  nqg_pkg::req_type   in_item,
   output logic               in_stall,
   output logic               job_valid,
   output nqg_pkg::job_type   job,
   input  wire                div_busy
);
   import nqg_pkg::*;

   localparam int CB    = $clog2(MAX_WIDTH);
   localparam int SB    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int DEPTH = MAX_WIDTH * MAX_CHANNELS;
   localparam int AB    = $clog2(DEPTH);
   localparam int WDEP  = 3 * MAX_CHANNELS;
   localparam int WB    = $clog2(WDEP);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_CALC = 2'd2;

   // line store: three rows per entry; window: 4 samples per column entry
   logic [23:0] line_mem [DEPTH];
   logic [31:0] win_mem  [WDEP];
   logic [23:0] line_rd_ff;
   logic [31:0] w0_ff, w1_ff, w2_ff;

   logic [1:0]      st_ff, st_in;
   logic [CB:0]     c_ff, c_in;
   logic [15:0]     r_ff, r_in;
   logic [SB:0]     s_ff, s_in;
   logic [CB:0]     cc_ff, cc_in;
   logic [15:0]     rr_ff, rr_in;
   logic [SB:0]     ss_ff, ss_in;
   logic [7:0]      pix_ff, pix_in;
   logic            jv_ff, jv_in;
   job_type         job_ff, job_in;

   logic [CB:0]  w_eff;
   logic [15:0]  h_eff;
   logic [SB:0]  n_eff;
   logic [CB:0]  c_use;
   logic [SB:0]  s_use;
   logic [15:0]  r_use;
   logic [AB-1:0] addr;
   logic [WB-1:0] wa0, wa1, wa2;
   logic [31:0]   col;
   logic [SUM_BITS-1:0] nw, ne, sw, se, tot;
   logic signed [SUM_BITS:0] gx, gy;

   // effective register values
   always_comb begin
      if (image_width < 11'd4) w_eff = (CB+1)'(4);
      else if ({21'd0, image_width} > MAX_WIDTH) w_eff = (CB+1)'(MAX_WIDTH);
      else w_eff = (CB+1)'(image_width);
      h_eff = (image_height < 16'd4) ? 16'd4 : image_height;
      if (channel_count == 3'd0) n_eff = (SB+1)'(1);
      else if ({29'd0, channel_count} > MAX_CHANNELS) n_eff = (SB+1)'(MAX_CHANNELS);
      else n_eff = (SB+1)'(channel_count);
   end

   assign in_stall  = (st_ff != ST_IDLE) | jv_ff;
   assign job_valid = jv_ff;
   assign job       = job_ff;

   // position of the arriving sample
   always_comb begin
      c_use = in_item.frame_start ? '0 : c_ff;
      r_use = in_item.frame_start ? '0 : r_ff;
      s_use = in_item.frame_start ? '0 : s_ff;
      if (c_use >= w_eff) c_use = '0;
      if (s_use >= n_eff) s_use = '0;
      addr = AB'(c_use[CB-1:0] * MAX_CHANNELS + s_use);
   end

   assign wa0 = WB'(ss_ff);
   assign wa1 = WB'(MAX_CHANNELS + ss_ff);
   assign wa2 = WB'(2 * MAX_CHANNELS + ss_ff);
   assign col = {line_rd_ff, pix_ff};

   // quadrant sums, window byte 3 is the oldest row
   always_comb begin
      nw = SUM_BITS'(w0_ff[31:24]) + SUM_BITS'(w0_ff[23:16])
         + SUM_BITS'(w1_ff[31:24]) + SUM_BITS'(w1_ff[23:16]);
      sw = SUM_BITS'(w0_ff[15:8]) + SUM_BITS'(w0_ff[7:0])
         + SUM_BITS'(w1_ff[15:8]) + SUM_BITS'(w1_ff[7:0]);
      ne = SUM_BITS'(w2_ff[31:24]) + SUM_BITS'(w2_ff[23:16])
         + SUM_BITS'(col[31:24]) + SUM_BITS'(col[23:16]);
      se = SUM_BITS'(w2_ff[15:8]) + SUM_BITS'(w2_ff[7:0])
         + SUM_BITS'(col[15:8]) + SUM_BITS'(col[7:0]);
      tot = nw + ne + sw + se + SUM_BITS'(4);
      gx = $signed({1'b0, ne + se}) - $signed({1'b0, nw + sw});
      gy = $signed({1'b0, ne + nw}) - $signed({1'b0, se + sw});
   end

   // sequencer: read stores, then compute and write back
   always_comb begin
      st_in = st_ff;
      c_in = c_ff; r_in = r_ff; s_in = s_ff;
      cc_in = cc_ff; rr_in = rr_ff; ss_in = ss_ff;
      pix_in = pix_ff;
      jv_in = jv_ff & div_busy;
      job_in = job_ff;
      unique case (st_ff)
         ST_IDLE: begin
            if (in_valid && !in_stall) begin
               st_in = ST_READ;
               cc_in = c_use; rr_in = r_use; ss_in = s_use;
               pix_in = in_item.pixel_sample;
            end
         end
         ST_READ: st_in = ST_CALC;
         ST_CALC: begin
            st_in = ST_IDLE;
            if (cc_ff >= (CB+1)'(3) && rr_ff >= 16'd3) begin
               jv_in = 1'b1;
               job_in.total = tot;
               job_in.neg_x = gx < 0;
               job_in.neg_y = gy < 0;
               job_in.mag_x = SUM_BITS'(gx < 0 ? -gx : gx);
               job_in.mag_y = SUM_BITS'(gy < 0 ? -gy : gy);
               job_in.channel_index = 2'(ss_ff);
               job_in.frame_end = (rr_ff == h_eff - 16'd1) && (cc_ff == w_eff - 1'b1)
                                  && (ss_ff == n_eff - 1'b1);
            end
            s_in = ss_ff + 1'b1; c_in = cc_ff; r_in = rr_ff;
            if (s_in >= n_eff) begin
               s_in = '0;
               c_in = cc_ff + 1'b1;
               if (c_in >= w_eff) begin
                  c_in = '0;
                  r_in = rr_ff + 16'd1;
                  if (r_in >= h_eff) r_in = '0;
               end
            end
         end
         default: st_in = ST_IDLE;
      endcase
      if (csr_write) begin
         c_in = '0; r_in = '0; s_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         c_ff <= '0; r_ff <= '0; s_ff <= '0;
         jv_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         c_ff <= c_in; r_ff <= r_in; s_ff <= s_in;
         jv_ff <= jv_in;
      end
      cc_ff <= cc_in; rr_ff <= rr_in; ss_ff <= ss_in;
      pix_ff <= pix_in;
      job_ff <= job_in;
   end

   // memory reads and write-back
   always_ff @(posedge clock) begin
      if (st_ff == ST_IDLE) line_rd_ff <= line_mem[addr];
      if (st_ff == ST_READ) begin
         w0_ff <= win_mem[wa0];
         w1_ff <= win_mem[wa1];
         w2_ff <= win_mem[wa2];
      end
      if (st_ff == ST_CALC) begin
         line_mem[AB'(cc_ff[CB-1:0] * MAX_CHANNELS + ss_ff)] <= col[23:0];
         win_mem[wa0] <= w1_ff;
         win_mem[wa1] <= w2_ff;
         win_mem[wa2] <= col;
      end
   end
endmodule
`default_nettype wire

### rtl/core/normalized_quadrant_gradient.sv
// Normalized quadrant gradient over a 4x4 window per channel.
// req_ channel: one sample per transaction (pixel_sample, frame_start), raster
// order with channels interleaved; accepted when req_valid is high and
// req_stall low.
// rsp_ channel: one transaction per complete 4x4 window (grad_x, grad_y in
// Q1.15, channel_index, frame_end); taken when rsp_valid high and rsp_stall low.
// csr_ channel: csr_index 0 width, 1 height, 2 channel count; a write also
// restarts the frame position.
// Flow: a sample passes through the line and window memories in steps
// (read line, read window, write back), and the next sample is accepted
// only after write back; a window sample also occupies the shared
// restoring divider, so samples that produce a gradient wait on it once
// the job register is full.
// Reset clears positions and handshake state; the memories hold whatever was
// there and are only used where written earlier in the frame.
// A stalled result holds in the divider's output register; a second window
// waits in the job register, and further samples stall on req_stall.
`default_nettype none
module normalized_quadrant_gradient #(
   parameter int MAX_WIDTH    = nqg_pkg::MAX_WIDTH_DEF,
   parameter int MAX_CHANNELS = nqg_pkg::MAX_CHANNELS_DEF
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  nqg_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output nqg_pkg::rsp_type  rsp_payload,
   input  wire               csr_valid,
   output logic              csr_ready,
   input  wire [1:0]         csr_index,
   input  wire [15:0]        csr_data
);
   import nqg_pkg::*;

   logic [10:0] width_ff;
   logic [15:0] height_ff;
   logic [2:0]  chan_ff;
   logic        csr_write;
   logic        job_valid, div_busy;
   job_type     job;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && (csr_index == CSR_WIDTH || csr_index == CSR_HEIGHT
                                    || csr_index == CSR_CHANNELS);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 11'd640;
         height_ff <= 16'd480;
         chan_ff   <= 3'd1;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_WIDTH:    width_ff  <= csr_data[10:0];
            CSR_HEIGHT:   height_ff <= csr_data;
            CSR_CHANNELS: chan_ff   <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   nqg_window #(.MAX_WIDTH(MAX_WIDTH), .MAX_CHANNELS(MAX_CHANNELS)) u_window (
      .clock(clock), .reset(reset), .csr_write(csr_write),
      .image_width(width_ff), .image_height(height_ff), .channel_count(chan_ff),
      .in_valid(req_valid), .in_item(req_payload), .in_stall(req_stall),
      .job_valid(job_valid), .job(job), .div_busy(div_busy)
   );

   nqg_divider u_divider (
      .clock(clock), .reset(reset), .job_valid(job_valid), .job(job),
      .busy(div_busy), .done_valid(rsp_valid), .done_take(~rsp_stall),
      .done(rsp_payload)
   );
endmodule
`default_nettype wire
